>>> rtl/core/dws_pkg.sv
`timescale 1ns / 1ps
package dws_pkg;
    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_SUCC   = 3'd1,
        OP_PRED   = 3'd2,
        OP_SCHED  = 3'd3,
        OP_NEXT   = 3'd4,
        OP_NOTIFY = 3'd5,
        OP_SPARE6 = 3'd6,
        OP_SPARE7 = 3'd7
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_NODE_WB,
        ST_SCHED_CHK,
        ST_POP_RD,
        ST_POP_WB,
        ST_WALK_LEN,
        ST_WALK_RD,
        ST_WALK_WAIT,
        ST_WALK_CHK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic clear;
        logic node_read;
        logic do_load;
        logic do_edge;
        logic sched_from_in;
        logic sched_from_walk;
        logic sched_check;
        logic pop_read;
        logic pop_write;
        logic walk_init;
        logic walk_read;
        logic walk_step;
        logic bump_notify;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       queue_empty;
        logic       walk_more;
        logic       clear_last;
    } t_status;
endpackage

>>> rtl/core/dedup_worklist_scheduler.sv
`timescale 1ns / 1ps
// Edge, schedule, notify and non-empty next add states after decode; load, unused codes and an empty next go to done.
// Notify walks the edges of one list, successors or predecessors by the set direction; a list holds at most MAX_DEGREE.
// Throughput: one transaction at a time; the next is accepted in the result cycle.
// Each edge costs an edge-memory read, a node-table read and a queue check/enqueue.
// Result strobe o_done is high one cycle; the receiver cannot stall.
// Synchronous active-low reset clears pointers and counters, then busy stays high during a
// clearing pass over the marks and list lengths of min(MAX_NODES, 256) entries.
module dedup_worklist_scheduler #(
    parameter int MAX_NODES  = 256,
    parameter int MAX_DEGREE = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_node_id,
    input  logic [7:0]  i_edge_target,
    input  logic        i_is_reachable,
    output logic        o_done,
    output logic        o_has_node,
    output logic [7:0]  o_popped_node,
    output logic [8:0]  o_pending_count,
    output logic [8:0]  o_peak_pending,
    output logic [31:0] o_scheduled_total,
    output logic [31:0] o_evaluation_total,
    output logic [31:0] o_notify_total,
    output logic        o_error_code
);
    dws_pkg::t_cmd    cmd;
    dws_pkg::t_status status;

    dws_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_status(status), .o_cmd(cmd), .o_busy(busy)
    );

    dws_datapath #(.MAX_NODES(MAX_NODES), .MAX_DEGREE(MAX_DEGREE)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_opcode(i_opcode), .i_node_id(i_node_id),
        .i_edge_target(i_edge_target), .i_is_reachable(i_is_reachable),
        .o_done(o_done), .o_has_node(o_has_node), .o_popped_node(o_popped_node),
        .o_pending_count(o_pending_count), .o_peak_pending(o_peak_pending),
        .o_scheduled_total(o_scheduled_total), .o_evaluation_total(o_evaluation_total),
        .o_notify_total(o_notify_total), .o_error_code(o_error_code)
    );
endmodule

>>> rtl/core/dws_ctrl.sv
`timescale 1ns / 1ps
module dws_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  dws_pkg::t_status i_status,
    output dws_pkg::t_cmd   o_cmd,
    output logic            o_busy
);
    dws_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dws_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dws_pkg::ST_CLEAR: begin
                if (i_status.clear_last) n_state = dws_pkg::ST_IDLE;
            end
            dws_pkg::ST_IDLE: begin
                if (i_start) n_state = dws_pkg::ST_DECODE;
            end
            dws_pkg::ST_DECODE: begin
                case (i_status.op)
                    dws_pkg::OP_SUCC:   n_state = dws_pkg::ST_NODE_WB;
                    dws_pkg::OP_PRED:   n_state = dws_pkg::ST_NODE_WB;
                    dws_pkg::OP_SCHED:  n_state = dws_pkg::ST_SCHED_CHK;
                    dws_pkg::OP_NEXT:   n_state = i_status.queue_empty ?
                                            dws_pkg::ST_DONE : dws_pkg::ST_POP_RD;
                    dws_pkg::OP_NOTIFY: n_state = dws_pkg::ST_WALK_LEN;
                    default:            n_state = dws_pkg::ST_DONE;
                endcase
            end
            dws_pkg::ST_NODE_WB:   n_state = dws_pkg::ST_DONE;
            dws_pkg::ST_SCHED_CHK: n_state = dws_pkg::ST_DONE;
            dws_pkg::ST_POP_RD:    n_state = dws_pkg::ST_POP_WB;
            dws_pkg::ST_POP_WB:    n_state = dws_pkg::ST_DONE;
            dws_pkg::ST_WALK_LEN:  n_state = dws_pkg::ST_WALK_RD;
            dws_pkg::ST_WALK_RD: begin
                n_state = i_status.walk_more ? dws_pkg::ST_WALK_WAIT : dws_pkg::ST_DONE;
            end
            dws_pkg::ST_WALK_WAIT: n_state = dws_pkg::ST_WALK_CHK;
            dws_pkg::ST_WALK_CHK:  n_state = dws_pkg::ST_WALK_RD;
            dws_pkg::ST_DONE:      n_state = dws_pkg::ST_IDLE;
            default:               n_state = dws_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != dws_pkg::ST_IDLE);
        case (r_state)
            dws_pkg::ST_CLEAR: o_cmd.clear = 1'b1;
            dws_pkg::ST_IDLE:  o_cmd.latch = i_start;
            dws_pkg::ST_DECODE: begin
                o_cmd.node_read     = 1'b1;
                o_cmd.do_load       = (i_status.op == dws_pkg::OP_LOAD);
                o_cmd.sched_from_in = (i_status.op == dws_pkg::OP_SCHED);
                o_cmd.bump_notify   = (i_status.op == dws_pkg::OP_NOTIFY);
            end
            dws_pkg::ST_NODE_WB:   o_cmd.do_edge = 1'b1;
            dws_pkg::ST_SCHED_CHK: o_cmd.sched_check = 1'b1;
            dws_pkg::ST_POP_RD:    o_cmd.pop_read = 1'b1;
            dws_pkg::ST_POP_WB:    o_cmd.pop_write = 1'b1;
            dws_pkg::ST_WALK_LEN:  o_cmd.walk_init = 1'b1;
            dws_pkg::ST_WALK_RD:   o_cmd.walk_read = i_status.walk_more;
            dws_pkg::ST_WALK_WAIT: o_cmd.sched_from_walk = 1'b1;
            dws_pkg::ST_WALK_CHK: begin
                o_cmd.sched_check = 1'b1;
                o_cmd.walk_step   = 1'b1;
            end
            dws_pkg::ST_DONE:      o_cmd.publish = 1'b1;
            default: ;
        endcase
    end

    a_start_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == dws_pkg::ST_DECODE))
        else $error("accept did not enter decode");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dws_pkg::ST_DONE) |=> !o_busy)
        else $error("done did not return to idle");
    a_one_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |=> !o_cmd.publish)
        else $error("double publish");
endmodule

>>> rtl/core/dws_datapath.sv
`timescale 1ns / 1ps
module dws_datapath #(
    parameter int MAX_NODES  = 256,
    parameter int MAX_DEGREE = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dws_pkg::t_cmd    i_cmd,
    output dws_pkg::t_status o_status,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic [2:0]       i_opcode,
    input  logic [7:0]       i_node_id,
    input  logic [7:0]       i_edge_target,
    input  logic             i_is_reachable,
    output logic             o_done,
    output logic             o_has_node,
    output logic [7:0]       o_popped_node,
    output logic [8:0]       o_pending_count,
    output logic [8:0]       o_peak_pending,
    output logic [31:0]      o_scheduled_total,
    output logic [31:0]      o_evaluation_total,
    output logic [31:0]      o_notify_total,
    output logic             o_error_code
);
    localparam int NB  = (MAX_NODES > 256) ? 256 : MAX_NODES;
    localparam int NW  = (NB > 1) ? $clog2(NB) : 1;
    localparam int CW  = $clog2(NB + 1);
    localparam int DW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int LW  = $clog2(MAX_DEGREE + 1);
    localparam int EW  = NW + DW;
    localparam int TD  = 1 << EW;

    logic            r_walk_backward;
    logic [2:0]      r_op;
    logic [7:0]      r_node, r_target;
    logic            r_mark;
    logic            r_reach [NB];
    logic            r_pend [NB];
    logic [LW-1:0]   r_slen [NB];
    logic [LW-1:0]   r_plen [NB];
    logic [7:0]      r_queue [NB];
    logic [7:0]      r_succ [TD];
    logic [7:0]      r_pred [TD];
    logic [NW-1:0]   r_head, r_tail, r_clr_idx;
    logic [CW-1:0]   r_count, r_peak;
    logic [31:0]     r_sched, r_eval, r_notify;
    logic [7:0]      r_cand, r_edge_rd, r_pop_rd;
    logic            r_rd_reach, r_rd_pend;
    logic [LW-1:0]   r_rd_slen, r_rd_plen;
    logic [LW-1:0]   r_idx, r_len;
    logic            r_has, r_err, r_done;
    logic [7:0]      r_popped;

    logic            node_ok, cand_ok, pop_ok;
    logic [NW-1:0]   node_ix, cand_ix, pop_ix, rd_ix, wr_ix;
    logic [LW-1:0]   cur_len, len_val;
    logic            sched_ok, edge_fits, rd_en;
    logic            reach_we, pend_we, slen_we, plen_we;
    logic            reach_val, pend_val;

    assign node_ok = ({24'd0, r_node} < MAX_NODES);
    assign cand_ok = ({24'd0, r_cand} < MAX_NODES);
    assign pop_ok  = ({24'd0, r_pop_rd} < MAX_NODES);
    assign node_ix = r_node[NW-1:0];
    assign cand_ix = r_cand[NW-1:0];
    assign pop_ix  = r_pop_rd[NW-1:0];
    assign cur_len = (r_op == dws_pkg::OP_SUCC) ? r_rd_slen : r_rd_plen;
    assign edge_fits = (cur_len < LW'(MAX_DEGREE));
    assign sched_ok = cand_ok && r_rd_reach && !r_rd_pend && (r_count < CW'(NB));

    assign rd_en = i_cmd.node_read || i_cmd.sched_from_walk;
    assign rd_ix = i_cmd.sched_from_walk ? r_edge_rd[NW-1:0] : node_ix;
    assign wr_ix = i_cmd.clear       ? r_clr_idx :
                   i_cmd.sched_check ? cand_ix   :
                   i_cmd.pop_write   ? pop_ix    : node_ix;

    assign reach_we  = i_cmd.clear || (i_cmd.do_load && node_ok);
    assign reach_val = !i_cmd.clear && r_mark;
    assign pend_we   = i_cmd.clear || (i_cmd.sched_check && sched_ok) ||
                       (i_cmd.pop_write && pop_ok);
    assign pend_val  = !i_cmd.clear && i_cmd.sched_check;
    assign slen_we   = i_cmd.clear ||
                       (i_cmd.do_edge && node_ok && edge_fits && (r_op == dws_pkg::OP_SUCC));
    assign plen_we   = i_cmd.clear ||
                       (i_cmd.do_edge && node_ok && edge_fits && (r_op != dws_pkg::OP_SUCC));
    assign len_val   = i_cmd.clear ? '0 : cur_len + 1'b1;

    assign o_status.op          = r_op;
    assign o_status.queue_empty = (r_count == '0);
    assign o_status.walk_more   = node_ok && (r_idx < r_len);
    assign o_status.clear_last  = (r_clr_idx == NW'(NB - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_backward <= 1'b0;
        end else if (i_cfg_we) begin
            r_walk_backward <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= i_opcode;
            r_node   <= i_node_id;
            r_target <= i_edge_target;
            r_mark   <= i_is_reachable;
        end
        if (reach_we) r_reach[wr_ix] <= reach_val;
        if (pend_we)  r_pend[wr_ix]  <= pend_val;
        if (slen_we)  r_slen[wr_ix]  <= len_val;
        if (plen_we)  r_plen[wr_ix]  <= len_val;
        if (rd_en) begin
            r_rd_reach <= r_reach[rd_ix];
            r_rd_pend  <= r_pend[rd_ix];
            r_rd_slen  <= r_slen[rd_ix];
            r_rd_plen  <= r_plen[rd_ix];
        end
        if (i_cmd.do_edge && node_ok && edge_fits) begin
            if (r_op == dws_pkg::OP_SUCC)
                r_succ[{node_ix, cur_len[DW-1:0]}] <= r_target;
            else
                r_pred[{node_ix, cur_len[DW-1:0]}] <= r_target;
        end
        if (i_cmd.walk_read) begin
            if (r_walk_backward) r_edge_rd <= r_pred[{node_ix, r_idx[DW-1:0]}];
            else                 r_edge_rd <= r_succ[{node_ix, r_idx[DW-1:0]}];
        end
        if (i_cmd.sched_check && sched_ok) r_queue[r_tail] <= r_cand;
        if (i_cmd.pop_read) r_pop_rd <= r_queue[r_head];
        if (i_cmd.sched_from_in)   r_cand <= r_node;
        if (i_cmd.sched_from_walk) r_cand <= r_edge_rd;
        if (i_cmd.walk_init) begin
            r_len <= r_walk_backward ? r_rd_plen : r_rd_slen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_head <= '0; r_tail <= '0; r_count <= '0; r_peak <= '0;
            r_sched <= '0; r_eval <= '0; r_notify <= '0;
            r_idx <= '0; r_has <= 1'b0; r_err <= 1'b0; r_popped <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.publish;
            if (i_cmd.clear) r_clr_idx <= r_clr_idx + 1'b1;
            if (i_cmd.latch) begin
                r_has <= 1'b0; r_err <= 1'b0; r_popped <= '0; r_idx <= '0;
            end
            if (i_cmd.do_edge && node_ok && !edge_fits) r_err <= 1'b1;
            if (i_cmd.bump_notify && (r_notify != '1)) r_notify <= r_notify + 1'b1;
            if (i_cmd.walk_step) r_idx <= r_idx + 1'b1;
            if (i_cmd.sched_check && sched_ok) begin
                r_tail  <= (r_tail == NW'(NB - 1)) ? '0 : r_tail + 1'b1;
                r_count <= r_count + 1'b1;
                if (r_count + 1'b1 > r_peak) r_peak <= r_count + 1'b1;
                if (r_sched != '1) r_sched <= r_sched + 1'b1;
            end
            if (i_cmd.pop_write) begin
                r_head  <= (r_head == NW'(NB - 1)) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
                r_has    <= 1'b1;
                r_popped <= r_pop_rd;
                if (r_eval != '1) r_eval <= r_eval + 1'b1;
            end
        end
    end

    assign o_done             = r_done;
    assign o_has_node         = r_has;
    assign o_popped_node      = r_popped;
    assign o_pending_count    = 9'(r_count);
    assign o_peak_pending     = 9'(r_peak);
    assign o_scheduled_total  = r_sched;
    assign o_evaluation_total = r_eval;
    assign o_notify_total     = r_notify;
    assign o_error_code       = r_err;

    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_count) else $error("peak below count");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NB)) else $error("count overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_write |-> (r_count != '0)) else $error("pop on empty");
endmodule

>>> dv/dedup_worklist_scheduler_tb.sv
`timescale 1ns / 1ps
module dedup_worklist_scheduler_tb;
    localparam int NODES = 256;
    localparam int DEGREE = 8;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] node_id;
        logic [7:0] edge_target;
        logic       is_reachable;
    } t_work;

    typedef struct packed {
        logic        has_node;
        logic [7:0]  popped_node;
        logic [8:0]  pending_count;
        logic [8:0]  peak_pending;
        logic [31:0] scheduled_total;
        logic [31:0] evaluation_total;
        logic [31:0] notify_total;
        logic        error_code;
    } t_status_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic [2:0]  i_opcode = '0;
    logic [7:0]  i_node_id = '0;
    logic [7:0]  i_edge_target = '0;
    logic        i_is_reachable = 1'b0;
    logic        o_done;
    logic        o_has_node;
    logic [7:0]  o_popped_node;
    logic [8:0]  o_pending_count;
    logic [8:0]  o_peak_pending;
    logic [31:0] o_scheduled_total;
    logic [31:0] o_evaluation_total;
    logic [31:0] o_notify_total;
    logic        o_error_code;

    dedup_worklist_scheduler u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_opcode           (i_opcode),
        .i_node_id          (i_node_id),
        .i_edge_target      (i_edge_target),
        .i_is_reachable     (i_is_reachable),
        .o_done             (o_done),
        .o_has_node         (o_has_node),
        .o_popped_node      (o_popped_node),
        .o_pending_count    (o_pending_count),
        .o_peak_pending     (o_peak_pending),
        .o_scheduled_total  (o_scheduled_total),
        .o_evaluation_total (o_evaluation_total),
        .o_notify_total     (o_notify_total),
        .o_error_code       (o_error_code)
    );

    always #2 i_clk = ~i_clk;

    // worklist mirror
    logic        reach_mark[NODES];
    logic        pend_mark[NODES];
    logic [7:0]  fifo_store[NODES];
    int          fifo_head, fifo_tail, fifo_count;
    logic [7:0]  succ_list[NODES][DEGREE];
    int          succ_cnt[NODES];
    logic [7:0]  pred_list[NODES][DEGREE];
    int          pred_cnt[NODES];
    logic [31:0] sched_cnt, eval_cnt, notify_cnt;
    int          peak_cnt;
    logic        walk_back;

    t_work        work_q[$];
    t_status_word status_q[$];
    int           errors = 0;
    int           cycles = 0;
    int           done_count = 0;
    int           notify_walks = 0;
    int           pops_seen = 0;
    int           full_errs = 0;
    bit           hold_sender = 1'b0;

    function automatic void add_work(t_work w);
        work_q.insert(work_q.size(), w);
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    function automatic void enqueue_node(logic [7:0] n);
        if (!reach_mark[n] || pend_mark[n] || fifo_count >= NODES)
            return;
        pend_mark[n] = 1'b1;
        fifo_store[fifo_tail] = n;
        fifo_tail = (fifo_tail + 1) % NODES;
        fifo_count++;
        sched_cnt = sat_inc(sched_cnt);
        if (fifo_count > peak_cnt)
            peak_cnt = fifo_count;
    endfunction

    function automatic t_status_word worklist_step(t_work w);
        t_status_word r;
        r = '0;
        case (w.opcode)
            dws_pkg::OP_LOAD: reach_mark[w.node_id] = w.is_reachable;
            dws_pkg::OP_SUCC: begin
                if (succ_cnt[w.node_id] >= DEGREE) begin
                    r.error_code = 1'b1;
                end else begin
                    succ_list[w.node_id][succ_cnt[w.node_id]] = w.edge_target;
                    succ_cnt[w.node_id]++;
                end
            end
            dws_pkg::OP_PRED: begin
                if (pred_cnt[w.node_id] >= DEGREE) begin
                    r.error_code = 1'b1;
                end else begin
                    pred_list[w.node_id][pred_cnt[w.node_id]] = w.edge_target;
                    pred_cnt[w.node_id]++;
                end
            end
            dws_pkg::OP_SCHED: enqueue_node(w.node_id);
            dws_pkg::OP_NEXT: begin
                if (fifo_count != 0) begin
                    r.popped_node = fifo_store[fifo_head];
                    fifo_head = (fifo_head + 1) % NODES;
                    fifo_count--;
                    pend_mark[r.popped_node] = 1'b0;
                    r.has_node = 1'b1;
                    eval_cnt = sat_inc(eval_cnt);
                end
            end
            dws_pkg::OP_NOTIFY: begin
                notify_cnt = sat_inc(notify_cnt);
                if (walk_back) begin
                    for (int i = 0; i < pred_cnt[w.node_id]; i++)
                        enqueue_node(pred_list[w.node_id][i]);
                end else begin
                    for (int i = 0; i < succ_cnt[w.node_id]; i++)
                        enqueue_node(succ_list[w.node_id][i]);
                end
            end
            default: ;
        endcase
        r.pending_count = fifo_count[8:0];
        r.peak_pending = peak_cnt[8:0];
        r.scheduled_total = sched_cnt;
        r.evaluation_total = eval_cnt;
        r.notify_total = notify_cnt;
        return r;
    endfunction

    // driver
    int gap = 0;
    logic busy_at_edge = 1'b1;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy_at_edge) begin
            start <= 1'b0;
            gap = $urandom_range(0, 5);
        end else if (!start && !hold_sender && work_q.size() != 0) begin
            if (gap > 0) begin
                gap--;
            end else begin
                i_opcode <= work_q[0].opcode;
                i_node_id <= work_q[0].node_id;
                i_edge_target <= work_q[0].edge_target;
                i_is_reachable <= work_q[0].is_reachable;
                start <= 1'b1;
            end
        end
    end

    // accept detection and prediction at the rising edge
    always @(posedge i_clk) begin
        t_work acc;
        busy_at_edge <= busy;
        cycles++;
        if (i_rst_n && start && !busy) begin
            acc = work_q[0];
            work_q.delete(0);
            status_q.insert(status_q.size(), worklist_step(acc));
            if (acc.opcode == dws_pkg::OP_NOTIFY)
                notify_walks++;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_status_word got, want;
        if (i_rst_n && o_done) begin
            got = {o_has_node, o_popped_node, o_pending_count, o_peak_pending,
                   o_scheduled_total, o_evaluation_total, o_notify_total, o_error_code};
            done_count++;
            if (o_has_node)
                pops_seen++;
            if (o_error_code)
                full_errs++;
            if (status_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, actual %h", $time, got);
            end else begin
                want = status_q[0];
                status_q.delete(0);
                if (got.has_node !== want.has_node || got.popped_node !== want.popped_node
                    || got.pending_count !== want.pending_count
                    || got.peak_pending !== want.peak_pending
                    || got.scheduled_total !== want.scheduled_total
                    || got.evaluation_total !== want.evaluation_total
                    || got.notify_total !== want.notify_total
                    || got.error_code !== want.error_code) begin
                    errors++;
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT_CYCLES) begin
            $display("dedup_worklist_scheduler_tb: FAIL");
            $finish;
        end
    end

    function automatic t_work mk(logic [2:0] op, logic [7:0] n, logic [7:0] t, logic m);
        t_work w;
        w.opcode = op;
        w.node_id = n;
        w.edge_target = t;
        w.is_reachable = m;
        return w;
    endfunction

    task automatic drain();
        wait (work_q.size() == 0);
        wait (status_q.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_direction(logic v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        walk_back = v;
    endtask

    // random content over a small node pool so lists fill and nodes repeat
    task automatic random_phase(int count);
        logic [7:0] pool_base;
        int r;
        pool_base = 8'($urandom_range(0, 255));
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                add_work(mk(3'($urandom_range(dws_pkg::OP_SPARE6, dws_pkg::OP_SPARE7)),
                            8'($urandom), 8'($urandom), 1'($urandom)));
            else if (r < 10)
                add_work(mk(3'($urandom_range(dws_pkg::OP_LOAD, dws_pkg::OP_NOTIFY)),
                            8'($urandom), 8'($urandom), 1'($urandom)));
            else if (r < 25)
                add_work(mk(dws_pkg::OP_LOAD, 8'(pool_base + $urandom_range(0, 15)),
                            8'($urandom), ($urandom_range(0, 3) != 0)));
            else if (r < 45)
                add_work(mk(3'($urandom_range(dws_pkg::OP_SUCC, dws_pkg::OP_PRED)),
                            8'(pool_base + $urandom_range(0, 15)),
                            8'(pool_base + $urandom_range(0, 15)), 1'($urandom)));
            else if (r < 60)
                add_work(mk(dws_pkg::OP_SCHED, 8'(pool_base + $urandom_range(0, 15)),
                            8'($urandom), 1'($urandom)));
            else if (r < 80)
                add_work(mk(dws_pkg::OP_NEXT, 8'($urandom), 8'($urandom), 1'($urandom)));
            else
                add_work(mk(dws_pkg::OP_NOTIFY, 8'(pool_base + $urandom_range(0, 15)),
                            8'($urandom), 1'($urandom)));
        end
    endtask

    initial begin
        for (int i = 0; i < NODES; i++) begin
            reach_mark[i] = 1'b0;
            pend_mark[i] = 1'b0;
            succ_cnt[i] = 0;
            pred_cnt[i] = 0;
        end
        fifo_head = 0;
        fifo_tail = 0;
        fifo_count = 0;
        sched_cnt = '0;
        eval_cnt = '0;
        notify_cnt = '0;
        peak_cnt = 0;
        walk_back = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_direction(1'b0);
        // empty pop, extremes, full list, reload of a pending node, unused codes
        add_work(mk(dws_pkg::OP_NEXT, 8'h00, 8'h00, 1'b0));
        add_work(mk(dws_pkg::OP_LOAD, 8'hFF, 8'h00, 1'b1));
        add_work(mk(dws_pkg::OP_LOAD, 8'h00, 8'hFF, 1'b1));
        add_work(mk(dws_pkg::OP_SCHED, 8'hFF, 8'h00, 1'b0));
        add_work(mk(dws_pkg::OP_SCHED, 8'hFF, 8'h00, 1'b0));
        for (int i = 0; i < 9; i++)
            add_work(mk(dws_pkg::OP_SUCC, 8'h00, (i == 0) ? 8'hFF : 8'h00, 1'b0));
        add_work(mk(dws_pkg::OP_PRED, 8'hFF, 8'h00, 1'b1));
        add_work(mk(dws_pkg::OP_LOAD, 8'hFF, 8'h00, 1'b0));
        add_work(mk(dws_pkg::OP_NOTIFY, 8'h00, 8'h00, 1'b0));
        add_work(mk(dws_pkg::OP_NEXT, 8'h00, 8'h00, 1'b0));
        add_work(mk(dws_pkg::OP_NOTIFY, 8'h00, 8'h00, 1'b0));
        add_work(mk(dws_pkg::OP_SPARE6, 8'h12, 8'h34, 1'b1));
        add_work(mk(dws_pkg::OP_SPARE7, 8'hED, 8'hCB, 1'b0));
        add_work(mk(dws_pkg::OP_NEXT, 8'h00, 8'h00, 1'b0));
        add_work(mk(dws_pkg::OP_NEXT, 8'h00, 8'h00, 1'b0));
        drain();

        write_direction(1'b1);
        add_work(mk(dws_pkg::OP_NOTIFY, 8'hFF, 8'h00, 1'b0));
        random_phase(150);
        drain();

        write_direction(1'b0);
        random_phase(150);
        wait (work_q.size() < 75);
        hold_sender = 1'b1;
        wait (!start);
        wait (status_q.size() == 0);
        repeat (40) @(posedge i_clk);
        hold_sender = 1'b0;
        drain();

        write_direction(1'b1);
        random_phase(130);
        drain();

        $display("covered %0d transactions: %0d notifies, %0d pops, %0d full-list drops",
                 done_count, notify_walks, pops_seen, full_errs);
        if (errors == 0)
            $display("dedup_worklist_scheduler_tb: PASS");
        else
            $display("dedup_worklist_scheduler_tb: FAIL");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/dws_pkg.sv
rtl/core/dws_ctrl.sv
rtl/core/dws_datapath.sv
rtl/core/dedup_worklist_scheduler.sv
dv/dedup_worklist_scheduler_tb.sv
